>>> rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// shared types and constants of the push-button dimmer control
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int CHANNELS     = 4;
    localparam int HOLD_W       = 9;
    localparam int LEVEL_W      = 8;
    localparam int LONG_W       = 8;
    localparam int RESEND_W     = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;

    localparam logic [HOLD_W-1:0]   HOLD_MAX    = '1;
    localparam logic [RESEND_W-1:0] RESEND_MAX  = '1;
    localparam logic [LEVEL_W-1:0]  FULL_LEVEL  = '1;

    localparam logic [LONG_W-1:0]   LONG_PRESS_RESET = LONG_W'(25);
    localparam logic [RESEND_W-1:0] RETRANSMIT_RESET = RESEND_W'(100);

    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_RETRANSMIT = CFG_INDEX_W'(1);

    typedef struct packed {
        logic               changed;
        logic [LEVEL_W-1:0] level;
    } t_chan_status;

endpackage

>>> rtl/pbd_channel.sv
// ----------------------------------------------------------------------------
// pbd_channel
// one light channel: hold counter, on flag and brightness, updated per tick
// ----------------------------------------------------------------------------
module pbd_channel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_pressed,
    input  logic [pbd_pkg::LONG_W-1:0]   i_long_press,
    output pbd_pkg::t_chan_status        o_status
);

    logic [pbd_pkg::HOLD_W-1:0]  r_hold, n_hold;
    logic                        r_on, n_on;
    logic [pbd_pkg::LEVEL_W-1:0] r_bright, n_bright;
    logic                        changed;
    logic [pbd_pkg::HOLD_W-1:0]  hold_inc;
    logic [pbd_pkg::HOLD_W-1:0]  long_ext;

    assign long_ext = {{(pbd_pkg::HOLD_W-pbd_pkg::LONG_W){1'b0}}, i_long_press};
    assign hold_inc = (r_hold < pbd_pkg::HOLD_MAX) ? r_hold + 1'b1 : r_hold;

    always_comb begin
        n_hold   = r_hold;
        n_on     = r_on;
        n_bright = r_bright;
        changed  = 1'b0;
        if (i_pressed) begin
            n_hold = hold_inc;
            if (hold_inc > long_ext) begin
                if (r_bright != '0) begin
                    n_on     = 1'b1;
                    n_bright = r_bright - 1'b1;
                    changed  = 1'b1;
                end else begin
                    n_on = 1'b0;
                end
            end
        end else begin
            if ((r_hold != '0) && (r_hold <= long_ext)) begin
                n_on     = ~r_on;
                n_bright = pbd_pkg::FULL_LEVEL;
                changed  = 1'b1;
            end
            n_hold = '0;
        end
    end

    assign o_status.changed = changed;
    assign o_status.level   = n_on ? n_bright : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_on     <= 1'b0;
            r_bright <= '0;
        end else if (i_step) begin
            r_hold   <= n_hold;
            r_on     <= n_on;
            r_bright <= n_bright;
        end
    end

endmodule

>>> rtl/push_button_dimmer_control.sv
// ----------------------------------------------------------------------------
// push_button_dimmer_control
// four-channel toggle-and-fade dimmer; emits a level frame on change or
// when the retransmit count runs out
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  tick in   in         i_in_valid / o_in_ready     i_pressed_0..3
//  frame     out        o_out_valid / i_out_ready   o_level_0..3
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
//  one word per cycle while the frame register is not stalled; a tick passes an
//  input register, then the channel update into the frame register.
//  a tick that causes no frame leaves no output word.
//  synchronous active-low reset clears all channel state and the counters.
//  a stalled frame holds the update stage; the input register still takes
//  one more word, if it is empty, before o_in_ready falls.
// ----------------------------------------------------------------------------
module push_button_dimmer_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_pressed_0,
    input  logic                              i_pressed_1,
    input  logic                              i_pressed_2,
    input  logic                              i_pressed_3,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pbd_pkg::LEVEL_W-1:0]       o_level_0,
    output logic [pbd_pkg::LEVEL_W-1:0]       o_level_1,
    output logic [pbd_pkg::LEVEL_W-1:0]       o_level_2,
    output logic [pbd_pkg::LEVEL_W-1:0]       o_level_3,
    input  logic                              i_cfg_we,
    input  logic [pbd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [pbd_pkg::LONG_W-1:0]    r_long_press;
    logic [pbd_pkg::RESEND_W-1:0]  r_retransmit;
    logic                          r_in_valid;
    logic [pbd_pkg::CHANNELS-1:0]  r_pressed;
    logic [pbd_pkg::RESEND_W-1:0]  r_resend, n_resend;
    logic                          r_out_valid;
    logic [pbd_pkg::LEVEL_W-1:0]   r_level [pbd_pkg::CHANNELS];
    pbd_pkg::t_chan_status         status  [pbd_pkg::CHANNELS];
    logic [pbd_pkg::CHANNELS-1:0]  chan_changed;
    logic                          out_free;
    logic                          step;
    logic                          send;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= pbd_pkg::LONG_PRESS_RESET;
            r_retransmit <= pbd_pkg::RETRANSMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pbd_pkg::REG_LONG_PRESS: r_long_press <= i_cfg_data[pbd_pkg::LONG_W-1:0];
                pbd_pkg::REG_RETRANSMIT: r_retransmit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free   = ~r_out_valid | i_out_ready;
    assign step       = r_in_valid & out_free;
    assign o_in_ready = ~r_in_valid | step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pressed <= {i_pressed_3, i_pressed_2, i_pressed_1, i_pressed_0};
        end
    end

    // channel updates
    for (genvar c = 0; c < pbd_pkg::CHANNELS; c++) begin : g_chan
        pbd_channel u_chan (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (step),
            .i_pressed    (r_pressed[c]),
            .i_long_press (r_long_press),
            .o_status     (status[c])
        );
        assign chan_changed[c] = status[c].changed;
    end

    // resend counter and frame decision
    assign n_resend = (r_resend < pbd_pkg::RESEND_MAX) ? r_resend + 1'b1 : r_resend;
    assign send     = (|chan_changed) || (n_resend > r_retransmit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resend <= '0;
        end else if (step) begin
            r_resend <= send ? '0 : n_resend;
        end
    end

    // frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step & send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && send) begin
            for (int c = 0; c < pbd_pkg::CHANNELS; c++) begin
                r_level[c] <= status[c].level;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level_0   = r_level[0];
    assign o_level_1   = r_level[1];
    assign o_level_2   = r_level[2];
    assign o_level_3   = r_level[3];

endmodule

>>> bench/tb_push_button_dimmer_control.sv
// ----------------------------------------------------------------------------
// tb_push_button_dimmer_control
// self-checking bench for the four-channel toggle-and-fade dimmer: a table of
// directed ticks and register writes, then random button sequences (short
// presses, presses right at the long-press boundary, long fades, glitches)
// under several register settings and idle patterns on both handshakes;
// every frame is compared with a typed frame or a behavioral model of the channel logic
// ----------------------------------------------------------------------------
module tb_push_button_dimmer_control;

    typedef logic [pbd_pkg::CHANNELS-1:0][pbd_pkg::LEVEL_W-1:0] t_frame;
    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FRAME} t_row_check;

    typedef struct packed {
        t_row_kind                        kind;
        logic [pbd_pkg::CHANNELS-1:0]     pressed;
        logic [pbd_pkg::CFG_INDEX_W-1:0]  index;
        logic [pbd_pkg::CFG_DATA_W-1:0]   data;
        t_row_check                       check;
        t_frame                           frame;
    } t_stim_row;

    localparam logic [pbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = pbd_pkg::CFG_INDEX_W'(2);
    localparam logic [pbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = pbd_pkg::CFG_INDEX_W'(3);

    localparam int N_ROWS         = 29;
    localparam int N_PHASES       = 6;
    localparam int PHASE_TICKS    = 55;
    localparam int SETTLE_CYCLES  = 6;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam int PHASE_LONG [N_PHASES] = '{25, 1, 0, 255, 3, 7};
    localparam int PHASE_RETX [N_PHASES] = '{100, 1, 0, 1000, 1023, 20};

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [pbd_pkg::CHANNELS-1:0]     pressed_bus = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [pbd_pkg::LEVEL_W-1:0]      o_level_0, o_level_1, o_level_2, o_level_3;
    logic                             i_cfg_we = 1'b0;
    logic [pbd_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [pbd_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    // model state
    logic [pbd_pkg::LONG_W-1:0]       long_q = pbd_pkg::LONG_PRESS_RESET;
    logic [pbd_pkg::RESEND_W-1:0]     retx_q = pbd_pkg::RETRANSMIT_RESET;
    logic [pbd_pkg::HOLD_W-1:0]       hold_q [pbd_pkg::CHANNELS];
    bit                               on_q [pbd_pkg::CHANNELS];
    logic [pbd_pkg::LEVEL_W-1:0]      bright_q [pbd_pkg::CHANNELS];
    logic [pbd_pkg::RESEND_W-1:0]     resend_q = '0;

    t_frame                           pending_frames [$];
    t_stim_row                        directed [N_ROWS];
    bit                               btn_held [pbd_pkg::CHANNELS];
    int                               btn_left [pbd_pkg::CHANNELS];
    int                               send_idle_pct = 11;
    int                               recv_idle_pct = 45;
    int                               cycles = 0;
    bit                               failed = 1'b0;

    push_button_dimmer_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pressed_0 (pressed_bus[0]),
        .i_pressed_1 (pressed_bus[1]),
        .i_pressed_2 (pressed_bus[2]),
        .i_pressed_3 (pressed_bus[3]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level_0   (o_level_0),
        .o_level_1   (o_level_1),
        .o_level_2   (o_level_2),
        .o_level_3   (o_level_3),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one sampling tick of the dimmer; returns 1 when a frame goes out
    function automatic bit dimmer_tick(input logic [pbd_pkg::CHANNELS-1:0] pressed,
                                       output t_frame frame);
        bit changed;
        changed = 1'b0;
        frame = '0;
        if (resend_q != pbd_pkg::RESEND_MAX) resend_q++;
        for (int c = 0; c < pbd_pkg::CHANNELS; c++) begin
            if (pressed[c]) begin
                if (hold_q[c] != pbd_pkg::HOLD_MAX) hold_q[c]++;
                if (hold_q[c] > long_q) begin
                    if (bright_q[c] != 0) begin
                        on_q[c] = 1'b1;
                        bright_q[c]--;
                        changed = 1'b1;
                    end else begin
                        on_q[c] = 1'b0;
                    end
                end
            end else begin
                if (hold_q[c] != 0 && hold_q[c] <= long_q) begin
                    on_q[c] = !on_q[c];
                    bright_q[c] = pbd_pkg::FULL_LEVEL;
                    changed = 1'b1;
                end
                hold_q[c] = '0;
            end
        end
        if (changed || resend_q > retx_q) begin
            resend_q = '0;
            for (int c = 0; c < pbd_pkg::CHANNELS; c++)
                frame[c] = on_q[c] ? bright_q[c] : '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_stim_row tick_row(input logic [pbd_pkg::CHANNELS-1:0] pressed,
                                           input t_row_check check,
                                           input t_frame frame);
        return '{kind: ROW_TICK, pressed: pressed, index: '0, data: '0,
                 check: check, frame: frame};
    endfunction

    function automatic t_stim_row cfg_row(input logic [pbd_pkg::CFG_INDEX_W-1:0] index,
                                          input logic [pbd_pkg::CFG_DATA_W-1:0] data);
        return '{kind: ROW_CFG, pressed: '0, index: index, data: data,
                 check: CHK_NONE, frame: '0};
    endfunction

    task automatic send_tick(input logic [pbd_pkg::CHANNELS-1:0] p,
                             input t_row_check check,
                             input t_frame typed);
        t_frame predicted;
        bit     has_frame;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        pressed_bus <= p;
        do @(posedge i_clk); while (!o_in_ready);
        has_frame = dimmer_tick(p, predicted);
        case (check)
            CHK_MODEL: if (has_frame) pending_frames.push_back(predicted);
            CHK_FRAME: pending_frames.push_back(typed);
            default: ;
        endcase
    endtask

    // register writes only once the pipe has drained
    task automatic write_reg(input logic [pbd_pkg::CFG_INDEX_W-1:0] index,
                             input logic [pbd_pkg::CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == pbd_pkg::REG_LONG_PRESS)
            long_q = data[pbd_pkg::LONG_W-1:0];
        else if (index == pbd_pkg::REG_RETRANSMIT)
            retx_q = data[pbd_pkg::RESEND_W-1:0];
    endtask

    // button sequences per channel: press, release, with rare glitches
    task automatic next_buttons(output logic [pbd_pkg::CHANNELS-1:0] p);
        int span;
        for (int c = 0; c < pbd_pkg::CHANNELS; c++) begin
            if (btn_left[c] == 0) begin
                btn_held[c] = !btn_held[c];
                if (!btn_held[c]) begin
                    btn_left[c] = $urandom_range(1, 6);
                end else begin
                    span = (long_q == 0) ? 1 : ((long_q < 10) ? int'(long_q) : 10);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: btn_left[c] = $urandom_range(1, span);
                        5:             btn_left[c] = (long_q == 0) ? 1 : int'(long_q);
                        6:             btn_left[c] = int'(long_q) + 1;
                        7, 8:          btn_left[c] = int'(long_q) + $urandom_range(2, 40);
                        default:       btn_left[c] = int'(long_q) + $urandom_range(100, 300);
                    endcase
                end
            end
            btn_left[c]--;
            p[c] = btn_held[c] ^ ($urandom_range(0, 19) == 0);
        end
    endtask

    always @(posedge i_clk) begin : frame_check
        t_frame seen;
        t_frame want;
        seen = {o_level_3, o_level_2, o_level_1, o_level_0};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected frame: level_0 %0d level_1 %0d level_2 %0d level_3 %0d",
                       seen[0], seen[1], seen[2], seen[3]);
                failed = 1'b1;
            end else begin
                want = pending_frames.pop_front();
                for (int c = 0; c < pbd_pkg::CHANNELS; c++) begin
                    if (seen[c] !== want[c]) begin
                        $error("level_%0d: expected %0d, got %0d", c, want[c], seen[c]);
                        failed = 1'b1;
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [pbd_pkg::CHANNELS-1:0] p;
        int                           ph;
        int                           ch;
        for (int c = 0; c < pbd_pkg::CHANNELS; c++) begin
            hold_q[c]   = '0;
            on_q[c]     = 1'b0;
            bright_q[c] = '0;
        end
        directed = '{
            tick_row(4'b0000, CHK_NONE,  '0),
            tick_row(4'b0001, CHK_NONE,  '0),
            tick_row(4'b0000, CHK_FRAME, 32'h0000_00FF),
            tick_row(4'b1111, CHK_NONE,  '0),
            tick_row(4'b0000, CHK_FRAME, 32'hFFFF_FF00),
            // long press of zero: every held tick fades
            cfg_row(pbd_pkg::REG_LONG_PRESS, 10'd0),
            tick_row(4'b0010, CHK_FRAME, 32'hFFFF_FE00),
            tick_row(4'b0010, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0),
            // retransmit of zero: frame every tick
            cfg_row(pbd_pkg::REG_RETRANSMIT, 10'd0),
            tick_row(4'b0000, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0),
            // upper data bits beyond the long-press register width are dropped
            cfg_row(pbd_pkg::REG_LONG_PRESS, 10'h3FF),
            cfg_row(pbd_pkg::REG_RETRANSMIT, 10'h3FF),
            cfg_row(REG_SPARE_2, 10'h155),
            cfg_row(REG_SPARE_3, 10'h2AA),
            tick_row(4'b0100, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0),
            tick_row(4'b1010, CHK_MODEL, '0),
            tick_row(4'b0101, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0),
            cfg_row(pbd_pkg::REG_LONG_PRESS, 10'd1),
            cfg_row(pbd_pkg::REG_RETRANSMIT, 10'd1),
            tick_row(4'b1001, CHK_MODEL, '0),
            tick_row(4'b1001, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0),
            tick_row(4'b1111, CHK_MODEL, '0),
            tick_row(4'b0000, CHK_MODEL, '0)
        };

        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG)
                write_reg(directed[r].index, directed[r].data);
            else
                send_tick(directed[r].pressed, directed[r].check, directed[r].frame);
        end

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 11 : ((m == 1) ? 45 : 0);
            recv_idle_pct = (m == 0) ? 45 : ((m == 1) ? 11 : 0);
            for (int k = 0; k < 2; k++) begin
                ph = m * 2 + k;
                write_reg(pbd_pkg::REG_LONG_PRESS, pbd_pkg::CFG_DATA_W'(PHASE_LONG[ph]));
                write_reg(pbd_pkg::REG_RETRANSMIT, pbd_pkg::CFG_DATA_W'(PHASE_RETX[ph]));
                for (int c = 0; c < pbd_pkg::CHANNELS; c++) begin
                    btn_held[c] = 1'b0;
                    btn_left[c] = 0;
                end
                repeat (PHASE_TICKS) begin
                    next_buttons(p);
                    send_tick(p, CHK_MODEL, '0);
                end
            end
        end

        // one endless hold: fade to off, hold and resend counters saturate
        write_reg(pbd_pkg::REG_LONG_PRESS, 10'd0);
        write_reg(pbd_pkg::REG_RETRANSMIT, 10'd1023);
        ch = 0;
        for (int c = 1; c < pbd_pkg::CHANNELS; c++)
            if (bright_q[c] < bright_q[ch]) ch = c;
        p = '0;
        p[ch] = 1'b1;
        repeat (int'(bright_q[ch]) + 1040) send_tick(p, CHK_MODEL, '0);
        send_tick('0, CHK_MODEL, '0);

        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/pbd_pkg.sv
rtl/pbd_channel.sv
rtl/push_button_dimmer_control.sv
bench/tb_push_button_dimmer_control.sv
